@@ hw/rtl/lds_pkg.sv @@
// Package for the lexicographic decimal sorter: shared types, constants and
// the power-of-ten table used to build sort keys. No dependencies.
`default_nettype none

package lds_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGITS_MAX = 10;
    localparam int NDIG_W   = 4;
    // 10^10 - 1 needs 34 bits
    localparam int PAD_W    = 34;
    localparam int SCALE_W  = 30;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = 2;

    localparam logic [SCALE_W-1:0] POW10 [DIGITS_MAX] = '{
        30'd1, 30'd10, 30'd100, 30'd1000, 30'd10000, 30'd100000,
        30'd1000000, 30'd10000000, 30'd100000000, 30'd1000000000
    };

    // Sort key: value left-aligned to ten decimal digits, then digit count.
    // Padded value first, shorter string first on a tie.
    typedef struct packed {
        logic [PAD_W-1:0]  padded;
        logic [NDIG_W-1:0] ndig;
    } t_key;

    typedef struct packed {
        t_key               key;
        logic [VALUE_W-1:0] value;
        logic               last;
    } t_entry;

    typedef struct packed {
        logic [VALUE_W-1:0] sorted_value;
        logic               last_res;
        logic               dropped;
    } t_result;

    // Number of decimal digits of v, 1 to 10.
    function automatic logic [NDIG_W-1:0] digit_count(input logic [VALUE_W-1:0] v);
        logic [NDIG_W-1:0] n;
        n = NDIG_W'(1);
        for (int k = 1; k < DIGITS_MAX; k++) begin
            if ({2'b00, v} >= {4'b0000, POW10[k]}) begin
                n = n + NDIG_W'(1);
            end
        end
        return n;
    endfunction

    // 10^(10 - n) for n in 1..10.
    function automatic logic [SCALE_W-1:0] pad_scale(input logic [NDIG_W-1:0] n);
        logic [SCALE_W-1:0] s;
        unique case (n)
            4'd1:    s = POW10[9];
            4'd2:    s = POW10[8];
            4'd3:    s = POW10[7];
            4'd4:    s = POW10[6];
            4'd5:    s = POW10[5];
            4'd6:    s = POW10[4];
            4'd7:    s = POW10[3];
            4'd8:    s = POW10[2];
            4'd9:    s = POW10[1];
            default: s = POW10[0];
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lds_if.sv @@
// Valid/ready channel interfaces for the sorter's input and result items.
// Depends on nothing.
`default_nettype none

interface lds_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface lds_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] sorted_value;
    logic        last_res;
    logic        dropped;

    modport source (output valid, output sorted_value, output last_res,
                    output dropped, input ready);
    modport sink   (input valid, input sorted_value, input last_res,
                    input dropped, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lds_front.sv @@
// Front end: two-stage key builder (digit count, then scale multiply).
// Depends on lds_pkg.
`default_nettype none

module lds_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [31:0]             i_value,
    input  wire logic                    i_last,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output lds_pkg::t_entry              o_entry
);
    import lds_pkg::*;

    logic                r_s1_valid;
    logic [VALUE_W-1:0]  r_s1_value;
    logic                r_s1_last;
    logic [NDIG_W-1:0]   r_s1_ndig;
    logic                r_s2_valid;
    t_entry              r_s2_entry;

    logic                s2_load;
    logic                s1_load;
    logic [VALUE_W+SCALE_W-1:0] product;

    assign s2_load = !r_s2_valid || i_ready;
    assign s1_load = !r_s1_valid || s2_load;
    assign o_ready = s1_load;
    assign product = {{SCALE_W{1'b0}}, r_s1_value} * {{VALUE_W{1'b0}}, pad_scale(r_s1_ndig)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (s2_load) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_valid) begin
            r_s1_value <= i_value;
            r_s1_last  <= i_last;
            r_s1_ndig  <= digit_count(i_value);
        end
        if (s2_load && r_s1_valid) begin
            r_s2_entry.key.padded <= product[PAD_W-1:0];
            r_s2_entry.key.ndig   <= r_s1_ndig;
            r_s2_entry.value      <= r_s1_value;
            r_s2_entry.last       <= r_s1_last;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_entry = r_s2_entry;

endmodule

`default_nettype wire

@@ hw/rtl/lds_queue.sv @@
// Short FIFO of keyed entries between front and back.
// Depends on lds_pkg.
`default_nettype none

module lds_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire lds_pkg::t_entry i_entry,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output lds_pkg::t_entry      o_entry
);
    import lds_pkg::*;

    localparam int CNT_W = Q_PTR_W + 1;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0]   r_fill;
    logic               push;
    logic               pop;

    assign o_ready = (r_fill != CNT_W'(Q_DEPTH));
    assign o_valid = (r_fill != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            unique case ({push, pop})
                2'b10:   r_fill <= r_fill + CNT_W'(1);
                2'b01:   r_fill <= r_fill - CNT_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lds_back.sv @@
// Back end: chain of sorting cells, insert one entry per cycle, then drain.
// Depends on lds_pkg.
`default_nettype none

module lds_back #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire lds_pkg::t_entry i_entry,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output lds_pkg::t_result     o_result
);
    import lds_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_ovf;
    logic               n_ovf;
    t_key               r_key [MAX_ITEMS];
    logic [VALUE_W-1:0] r_val [MAX_ITEMS];
    t_key               n_key [MAX_ITEMS];
    logic [VALUE_W-1:0] n_val [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] lt;
    logic               pop;
    logic               insert;
    logic               shift_out;
    logic               full;
    logic               final_res;

    assign full      = (r_count == CNT_W'(MAX_ITEMS));
    assign o_ready   = (r_state == ST_FILL);
    assign pop       = i_valid && o_ready;
    assign insert    = pop && !full;
    assign o_valid   = (r_state == ST_DRAIN);
    assign shift_out = o_valid && i_ready;
    assign final_res = (r_count == CNT_W'(1));

    assign o_result.sorted_value = r_val[0];
    assign o_result.last_res     = final_res;
    assign o_result.dropped      = r_ovf && final_res;

    // Empty cells count as larger than any key.
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            lt[i] = (CNT_W'(i) >= r_count) || (i_entry.key < r_key[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            n_key[i] = r_key[i];
            n_val[i] = r_val[i];
            if (insert && lt[i]) begin
                if (i > 0 && lt[(i > 0) ? i - 1 : 0]) begin
                    n_key[i] = r_key[(i > 0) ? i - 1 : 0];
                    n_val[i] = r_val[(i > 0) ? i - 1 : 0];
                end else begin
                    n_key[i] = i_entry.key;
                    n_val[i] = i_entry.value;
                end
            end else if (shift_out && i < MAX_ITEMS - 1) begin
                n_key[i] = r_key[(i < MAX_ITEMS - 1) ? i + 1 : i];
                n_val[i] = r_val[(i < MAX_ITEMS - 1) ? i + 1 : i];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        unique case (r_state)
            ST_FILL: begin
                if (pop) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_entry.last) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (shift_out) begin
                    n_count = r_count - CNT_W'(1);
                    if (final_res) begin
                        n_state = ST_FILL;
                        n_ovf   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_val <= n_val;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lexicographic_decimal_sorter_top.sv @@
// Top level of the lexicographic decimal sorter: front key builder, queue
// and sorting-cell back end. Depends on lds_pkg, lds_if, lds_front,
// lds_queue and lds_back.
//
//  channel    dir  payload                           handshake
//  i_in_ch    in   value[31:0], last                 valid & ready
//  o_out_ch   out  sorted_value[31:0], last_res,     valid & ready
//                  dropped
//
// Input items are taken one per cycle while the cell chain is filling; each
// item passes through both key-builder stages and then the queue. A run's
// results leave one per cycle, while the output is ready, from the head of
// the cell chain, and during that drain the back end takes no new item; the
// front and queue still absorb up to six items. Reset is synchronous, active
// low, clears all control state; no clearing pass; both sides may stall freely.
`default_nettype none

module lexicographic_decimal_sorter_top #(
    parameter int MAX_ITEMS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lds_in_if.sink    i_in_ch,
    lds_out_if.source o_out_ch
);
    import lds_pkg::*;

    // front -> queue
    logic    fq_valid;
    logic    fq_ready;
    t_entry  fq_entry;
    // queue -> back
    logic    qb_valid;
    logic    qb_ready;
    t_entry  qb_entry;
    // back -> result port
    t_result res;

    // Key builder: decimal length, then value scaled to ten digits.
    lds_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_ch.valid),
        .o_ready (i_in_ch.ready),
        .i_value (i_in_ch.value),
        .i_last  (i_in_ch.last),
        .o_valid (fq_valid),
        .i_ready (fq_ready),
        .o_entry (fq_entry)
    );

    // Decouples the key builder from the drain of the cell chain.
    lds_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_entry (fq_entry),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_entry (qb_entry)
    );

    // Sorting cells; insert by key, drop past capacity, drain on last.
    lds_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (qb_valid),
        .o_ready  (qb_ready),
        .i_entry  (qb_entry),
        .o_valid  (o_out_ch.valid),
        .i_ready  (o_out_ch.ready),
        .o_result (res)
    );

    assign o_out_ch.sorted_value = res.sorted_value;
    assign o_out_ch.last_res     = res.last_res;
    assign o_out_ch.dropped      = res.dropped;

endmodule

`default_nettype wire
